// ===== sv/pitb_pkg.sv =====
// pitb_pkg: constants, request codes and the sweep record for the timer bank
// used by pitb_cell and the top level of the periodic interval timer bank
package pitb_pkg;

    localparam int unsigned SLOT_COUNT = 4;
    localparam int unsigned IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned TIME_W     = 48;
    localparam int unsigned PERIOD_W   = 31;
    localparam int unsigned SID_W      = 2;
    localparam int unsigned INDEX_W    = 2;
    localparam int unsigned FIRED_W    = 4;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type             req;
        logic [TIME_W-1:0]     now;
        logic [PERIOD_W-1:0]   period;
        logic [SID_W-1:0]      sid;
        logic                  found;
        logic [INDEX_W-1:0]    index;
        logic [FIRED_W-1:0]    fired;
        logic                  any;
        logic [TIME_W-1:0]     earliest;
    } t_sweep;

endpackage

// ===== sv/pitb_req_if.sv =====
// pitb_req_if: request channel of the timer bank, valid/ready with payload
// depends on nothing
interface pitb_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [47:0] now_ms;
    logic [30:0] period_ms;
    logic [1:0]  slot_id;

    modport source (output valid, req_type, now_ms, period_ms, slot_id, input ready);
    modport sink   (input valid, req_type, now_ms, period_ms, slot_id, output ready);
endinterface

// ===== sv/pitb_rsp_if.sv =====
// pitb_rsp_if: result channel of the timer bank, valid/ready with payload
// depends on nothing
interface pitb_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  slot_index;
    logic        bank_full;
    logic [3:0]  fired_mask;
    logic [47:0] wait_ms;
    logic        none_pending;

    modport source (output valid, slot_index, bank_full, fired_mask, wait_ms, none_pending,
                    input ready);
    modport sink   (input valid, slot_index, bank_full, fired_mask, wait_ms, none_pending,
                    output ready);
endinterface

// ===== sv/pitb_cell.sv =====
// pitb_cell: one timer slot, holds active flag, period and deadline
// updates the sweep record passing through it; depends on pitb_pkg
module pitb_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [pitb_pkg::IDX_W-1:0] i_cell_idx,
    input  logic                       i_vld,
    input  pitb_pkg::t_sweep           i_sweep,
    output pitb_pkg::t_sweep           o_sweep
);

    logic                          r_active;
    logic [pitb_pkg::PERIOD_W-1:0] r_period;
    logic [pitb_pkg::TIME_W-1:0]   r_deadline;
    logic                          n_active;
    logic [pitb_pkg::PERIOD_W-1:0] n_period;
    logic [pitb_pkg::TIME_W-1:0]   n_deadline;

    logic [pitb_pkg::IDX_W+1:0]    idx_ext;
    logic [pitb_pkg::IDX_W+1:0]    sid_ext;
    logic [pitb_pkg::TIME_W-1:0]   period_ext;
    logic                          due;

    assign idx_ext    = {2'b00, i_cell_idx};
    assign sid_ext    = {{pitb_pkg::IDX_W{1'b0}}, i_sweep.sid};
    assign period_ext = {{(pitb_pkg::TIME_W-pitb_pkg::PERIOD_W){1'b0}}, r_period};
    assign due        = r_active && (r_deadline <= i_sweep.now);

    always_comb begin
        n_active   = r_active;
        n_period   = r_period;
        n_deadline = r_deadline;
        o_sweep    = i_sweep;
        unique case (i_sweep.req)
            pitb_pkg::REQ_ALLOC: begin
                if (!i_sweep.found && !r_active) begin
                    n_active      = 1'b1;
                    n_period      = i_sweep.period;
                    n_deadline    = i_sweep.now + {{(pitb_pkg::TIME_W-pitb_pkg::PERIOD_W){1'b0}},
                                                   i_sweep.period};
                    o_sweep.found = 1'b1;
                    o_sweep.index = idx_ext[1:0];
                end
            end
            pitb_pkg::REQ_CLEAR: begin
                if (sid_ext == idx_ext) begin
                    n_active = 1'b0;
                end
            end
            pitb_pkg::REQ_TICK: begin
                if (due) begin
                    n_deadline = r_deadline + period_ext;
                    if (idx_ext < (pitb_pkg::IDX_W+2)'(pitb_pkg::FIRED_W)) begin
                        o_sweep.fired[idx_ext[1:0]] = 1'b1;
                    end
                end
                if (r_active && (!i_sweep.any || n_deadline < i_sweep.earliest)) begin
                    o_sweep.any      = 1'b1;
                    o_sweep.earliest = n_deadline;
                end
            end
            pitb_pkg::REQ_NONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_vld) begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_period   <= n_period;
            r_deadline <= n_deadline;
        end
    end

endmodule

// ===== sv/periodic_interval_timer_bank.sv =====
// periodic_interval_timer_bank: top level, a row of timer slot cells
// depends on pitb_pkg, pitb_req_if, pitb_rsp_if and pitb_cell
//
// A request walks the row of slot cells one cell per cycle, each cell updating
// its own slot, and is handed from the last stage register into a result
// register once that register is free. One request is in the row at a time,
// so a new request is taken only after the previous one has left the row; the
// next request is taken while a finished result still waits.
module periodic_interval_timer_bank (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pitb_req_if.sink    i_req,
    pitb_rsp_if.source  o_rsp
);

    localparam int unsigned N = pitb_pkg::SLOT_COUNT;

    pitb_pkg::t_sweep r_stage [N+1];
    pitb_pkg::t_sweep cell_out [N];
    logic [N:0]       r_vld;
    logic [N:0]       n_vld;
    logic             accept;
    logic             drain;

    logic                        r_out_vld;
    logic [1:0]                  r_slot_index;
    logic                        r_bank_full;
    logic [3:0]                  r_fired_mask;
    logic [pitb_pkg::TIME_W-1:0] r_wait_ms;
    logic                        r_none_pending;

    pitb_pkg::t_sweep            tail;
    logic [pitb_pkg::TIME_W-1:0] diff;

    assign i_req.ready = ~|r_vld;
    assign accept      = i_req.valid && i_req.ready;
    assign tail        = r_stage[N];
    assign drain       = r_vld[N] && (!r_out_vld || o_rsp.ready);
    assign diff        = tail.earliest - tail.now;

    always_comb begin
        n_vld[0] = accept;
        for (int i = 1; i < N; i++) begin
            n_vld[i] = r_vld[i-1];
        end
        n_vld[N] = r_vld[N-1] | (r_vld[N] & ~drain);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stage[0].req      <= pitb_pkg::t_req_type'(i_req.req_type);
            r_stage[0].now      <= i_req.now_ms;
            r_stage[0].period   <= i_req.period_ms;
            r_stage[0].sid      <= i_req.slot_id;
            r_stage[0].found    <= 1'b0;
            r_stage[0].index    <= '0;
            r_stage[0].fired    <= '0;
            r_stage[0].any      <= 1'b0;
            r_stage[0].earliest <= '0;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        pitb_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (pitb_pkg::IDX_W'(g)),
            .i_vld      (r_vld[g]),
            .i_sweep    (r_stage[g]),
            .o_sweep    (cell_out[g])
        );

        always_ff @(posedge i_clk) begin
            if (r_vld[g]) begin
                r_stage[g+1] <= cell_out[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (drain) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain) begin
            r_slot_index   <= tail.index;
            r_bank_full    <= (tail.req == pitb_pkg::REQ_ALLOC) && !tail.found;
            r_fired_mask   <= tail.fired;
            r_none_pending <= (tail.req == pitb_pkg::REQ_TICK) && !tail.any;
            if ((tail.req == pitb_pkg::REQ_TICK) && tail.any && (tail.earliest > tail.now)) begin
                r_wait_ms <= diff;
            end else begin
                r_wait_ms <= '0;
            end
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.slot_index   = r_slot_index;
    assign o_rsp.bank_full    = r_bank_full;
    assign o_rsp.fired_mask   = r_fired_mask;
    assign o_rsp.wait_ms      = r_wait_ms;
    assign o_rsp.none_pending = r_none_pending;

endmodule
